// ===== src/falt_pkg.sv =====
// Shared types and constants of the failed-attempt lockout table.
`timescale 1ns / 1ps
package falt_pkg;

	localparam int SRC_W = 32;
	localparam int COUNT_W = 8;
	localparam int TIME_W = 40;
	localparam int CFG_W = 17;
	localparam int SEC_W = 17;
	localparam int MS_W = 27;
	localparam int DIVIDEND_W = 28;

	// Division by 1000 is a shift by three followed by an exact reciprocal
	// multiplication for 125, valid for every dividend below 2^28.
	localparam int DIV_PRE_SHIFT = 3;
	localparam int RECIP_SHIFT = 32;
	localparam int RECIP_W = 26;
	localparam longint unsigned DIV_ODD = 1000 >> DIV_PRE_SHIFT;

	localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);
	localparam logic [DIVIDEND_W-1:0] ROUND_UP_MS = DIVIDEND_W'(999);
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [RECIP_W-1:0] DIV_RECIP =
		RECIP_W'(((64'd1 << RECIP_SHIFT) + DIV_ODD - 64'd1) / DIV_ODD);
	localparam logic [COUNT_W-1:0] MAX_ATTEMPTS_RESET = COUNT_W'(5);
	localparam logic [MS_W-1:0] LOCKOUT_MS_RESET = MS_W'(300 * 1000);

	localparam logic [0:0] REG_MAX_ATTEMPTS = 1'b0;
	localparam logic [0:0] REG_LOCKOUT_SECONDS = 1'b1;

	typedef enum logic [1:0] {
		CMD_FAIL = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic valid;
		logic [SRC_W-1:0] source;
		logic [COUNT_W-1:0] count;
		logic locked;
		logic [TIME_W-1:0] deadline;
	} entry_t;

endpackage

// ===== src/falt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module falt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/failed_attempt_lockout_table.sv =====
// Top level of the failed-attempt lockout table: sequencer, scan datapath and divider.
//
// Each accepted command word yields one result word. A tick skips the scan and goes from
// acceptance straight to ST_FINISH. Failure, clear and query commands scan the whole
// table through the single read port of the entry RAM, one entry per cycle, then pass
// through ST_DECIDE to ST_FINISH; when the reported entry is locked, a reciprocal
// multiplication that divides by 1000 turns the remaining milliseconds into seconds
// in ST_DIV. A new command is taken only once the previous one has been handed to
// the result register. After reset a clearing pass invalidates every entry before
// the first command is accepted; configuration writes are taken at any time.
`timescale 1ns / 1ps
module failed_attempt_lockout_table
	import falt_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [CFG_W-1:0] cfg_data,
	input logic cmd_valid,
	output logic cmd_stall,
	input logic [1:0] command,
	input logic [SRC_W-1:0] source_id,
	output logic rsp_valid,
	input logic rsp_stall,
	output logic locked,
	output logic [SEC_W-1:0] remaining_seconds,
	output logic [COUNT_W-1:0] failure_count,
	output logic status
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
	localparam int QUO_IN_W = DIVIDEND_W - DIV_PRE_SHIFT;
	localparam int PROD_W = QUO_IN_W + RECIP_W;

	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [SRC_W-1:0] src_q;
	logic [TIME_W-1:0] now_q;
	logic [COUNT_W-1:0] max_q;
	logic [MS_W-1:0] lockout_ms_q;
	logic [CNT_W-1:0] cnt_q;
	logic rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	logic match_found_q;
	logic [IDX_W-1:0] match_idx_q;
	logic [COUNT_W-1:0] match_count_q;
	logic match_locked_q;
	logic [TIME_W-1:0] match_deadline_q;
	logic free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	logic res_locked_q;
	logic [COUNT_W-1:0] res_count_q;
	logic res_status_q;
	logic [DIVIDEND_W-1:0] div_rem_q;
	logic [SEC_W-1:0] div_quo_q;

	logic rsp_valid_q;
	logic locked_q;
	logic [SEC_W-1:0] remaining_q;
	logic [COUNT_W-1:0] failure_count_q;
	logic status_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	entry_t ram_wdata;
	entry_t rd_entry;

	logic accept;
	logic rsp_load;
	logic issue_read;
	logic scan_done;
	logic rd_stale;
	logic rd_live;
	logic cap_match;
	logic cap_free;
	logic fail_ok;
	logic [IDX_W-1:0] fail_idx;
	logic [COUNT_W-1:0] base_count;
	logic base_locked;
	logic [COUNT_W-1:0] new_count;
	logic new_locked;
	logic [TIME_W:0] dl_sum;
	logic [TIME_W-1:0] dl;
	logic [TIME_W-1:0] sat_left;
	logic [TIME_W-1:0] query_left;
	logic [DIVIDEND_W-1:0] fail_dividend;
	logic [DIVIDEND_W-1:0] query_dividend;
	logic [PROD_W-1:0] div_prod;
	logic [MS_W-1:0] cfg_lockout_ms;

	falt_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_ENTRIES)
	) u_entries (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_entry)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign accept = cmd_valid && !cmd_stall;
	assign rsp_load = (state_q == ST_FINISH) && (!rsp_valid_q || !rsp_stall);
	assign issue_read = (state_q == ST_SCAN) && (cnt_q < ENTRIES_CNT);
	assign scan_done = rd_valid_s1 && (rd_idx_s1 == LAST_IDX);
	assign ram_raddr = cnt_q[IDX_W-1:0];

	assign rd_stale = rd_entry.valid && (now_q >= rd_entry.deadline);
	assign rd_live = rd_entry.valid && (now_q < rd_entry.deadline);
	assign cap_match = rd_valid_s1 && !match_found_q && rd_live && (rd_entry.source == src_q);
	assign cap_free = rd_valid_s1 && !free_found_q && (!rd_entry.valid || rd_stale);

	assign fail_ok = match_found_q || free_found_q;
	assign fail_idx = match_found_q ? match_idx_q : free_idx_q;
	assign base_count = match_found_q ? match_count_q : '0;
	assign base_locked = match_found_q && match_locked_q;
	assign new_count = (base_count == COUNT_MAX) ? COUNT_MAX : base_count + COUNT_W'(1);
	assign new_locked = base_locked || (new_count >= max_q);
	assign dl_sum = {1'b0, now_q} + {{(TIME_W + 1 - MS_W){1'b0}}, lockout_ms_q};
	assign dl = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
	assign sat_left = TIME_MAX - now_q;
	assign fail_dividend = (dl_sum[TIME_W] ? sat_left[DIVIDEND_W-1:0]
		: DIVIDEND_W'(lockout_ms_q)) + ROUND_UP_MS;
	assign query_left = match_deadline_q - now_q;
	assign query_dividend = query_left[DIVIDEND_W-1:0] + ROUND_UP_MS;

	assign div_prod = PROD_W'(div_rem_q[DIVIDEND_W-1:DIV_PRE_SHIFT]) * PROD_W'(DIV_RECIP);
	assign cfg_lockout_ms = MS_W'(cfg_data) * MS_PER_S;

	always_comb begin
		state_d = state_q;
		ram_we = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = rd_entry;
		ram_wdata.valid = 1'b0;
		case (state_q)
			ST_INIT: begin
				ram_we = 1'b1;
				ram_waddr = cnt_q[IDX_W-1:0];
				ram_wdata = '0;
				if (cnt_q == LAST_CNT) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (cmd_t'(command) == CMD_TICK) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (rd_valid_s1) begin
					if (cmd_q == CMD_FAIL) begin
						ram_we = rd_stale;
					end else if (cmd_q == CMD_CLEAR) begin
						ram_we = rd_entry.valid && (rd_entry.source == src_q);
					end
				end
				if (scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_FINISH;
				if (cmd_q == CMD_FAIL && fail_ok) begin
					ram_we = 1'b1;
					ram_waddr = fail_idx;
					ram_wdata = '{valid: 1'b1, source: src_q, count: new_count,
						locked: new_locked, deadline: dl};
					if (new_locked) begin
						state_d = ST_DIV;
					end
				end else if (cmd_q == CMD_QUERY && match_found_q && match_locked_q) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (rsp_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_valid_s1 <= 1'b0;
			now_q <= '0;
			max_q <= MAX_ATTEMPTS_RESET;
			lockout_ms_q <= LOCKOUT_MS_RESET;
			match_found_q <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue_read;
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_ATTEMPTS: max_q <= cfg_data[COUNT_W-1:0];
					REG_LOCKOUT_SECONDS: lockout_ms_q <= cfg_lockout_ms;
					default: ;
				endcase
			end
			if (state_q == ST_INIT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (accept) begin
				cnt_q <= '0;
			end else if (issue_read) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (accept) begin
				match_found_q <= 1'b0;
				free_found_q <= 1'b0;
				if (cmd_t'(command) == CMD_TICK && now_q != TIME_MAX) begin
					now_q <= now_q + TIME_W'(1);
				end
			end else begin
				if (cap_match) begin
					match_found_q <= 1'b1;
				end
				if (cap_free) begin
					free_found_q <= 1'b1;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cnt_q[IDX_W-1:0];
		if (accept) begin
			cmd_q <= cmd_t'(command);
			src_q <= source_id;
			res_locked_q <= 1'b0;
			res_count_q <= '0;
			res_status_q <= 1'b0;
			div_quo_q <= '0;
		end
		if (cap_match) begin
			match_idx_q <= rd_idx_s1;
			match_count_q <= rd_entry.count;
			match_locked_q <= rd_entry.locked;
			match_deadline_q <= rd_entry.deadline;
		end
		if (cap_free) begin
			free_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_DECIDE) begin
			if (cmd_q == CMD_FAIL) begin
				if (fail_ok) begin
					res_count_q <= new_count;
					res_locked_q <= new_locked;
					div_rem_q <= fail_dividend;
				end else begin
					res_status_q <= 1'b1;
				end
			end else if (cmd_q == CMD_QUERY && match_found_q) begin
				res_count_q <= match_count_q;
				res_locked_q <= match_locked_q;
				div_rem_q <= query_dividend;
			end
		end
		if (state_q == ST_DIV) begin
			div_quo_q <= div_prod[RECIP_SHIFT+SEC_W-1:RECIP_SHIFT];
		end
		if (rsp_load) begin
			locked_q <= res_locked_q;
			remaining_q <= div_quo_q;
			failure_count_q <= res_count_q;
			status_q <= res_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign locked = locked_q;
	assign remaining_seconds = remaining_q;
	assign failure_count = failure_count_q;
	assign status = status_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the failed-attempt lockout table.
`timescale 1ns / 1ps
module testbench;
	import falt_pkg::*;

	localparam int TABLE_ENTRIES = 16;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam longint unsigned MS_PER_SECOND = 1000;
	localparam longint unsigned ROUND_UP = 999;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic locked;
		logic [SEC_W-1:0] seconds;
		logic [COUNT_W-1:0] count;
		logic dropped;
	} verdict_t;

	typedef struct packed {
		cmd_t op;
		logic [SRC_W-1:0] src;
		logic known;
		verdict_t want;
	} script_row_t;

	localparam verdict_t NIL = '0;
	localparam int SCRIPT_LEN = 26;
	localparam int RECONFIG_ROW = 17;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{CMD_QUERY, 32'h0000_0000, 1'b1, NIL},
		'{CMD_TICK, 32'h0000_0000, 1'b1, NIL},
		'{CMD_FAIL, 32'h0000_0000, 1'b1, '{1'b0, 17'd0, 8'd1, 1'b0}},
		'{CMD_QUERY, 32'hFFFF_FFFF, 1'b1, NIL},
		'{CMD_FAIL, 32'hFFFF_FFFF, 1'b1, '{1'b0, 17'd0, 8'd1, 1'b0}},
		'{CMD_FAIL, 32'h0000_0000, 1'b1, '{1'b0, 17'd0, 8'd2, 1'b0}},
		'{CMD_FAIL, 32'h0000_0000, 1'b0, NIL},
		'{CMD_FAIL, 32'h0000_0000, 1'b0, NIL},
		'{CMD_FAIL, 32'h0000_0000, 1'b1, '{1'b1, 17'd300, 8'd5, 1'b0}},
		'{CMD_TICK, 32'h0000_0000, 1'b1, NIL},
		'{CMD_QUERY, 32'h0000_0000, 1'b1, '{1'b1, 17'd300, 8'd5, 1'b0}},
		'{CMD_FAIL, 32'hFFFF_FFFF, 1'b0, NIL},
		'{CMD_CLEAR, 32'hFFFF_FFFF, 1'b1, NIL},
		'{CMD_QUERY, 32'hFFFF_FFFF, 1'b1, NIL},
		'{CMD_FAIL, 32'h0000_0000, 1'b1, '{1'b1, 17'd300, 8'd6, 1'b0}},
		'{CMD_CLEAR, 32'h0000_0000, 1'b1, NIL},
		'{CMD_QUERY, 32'h0000_0000, 1'b1, NIL},
		'{CMD_FAIL, 32'h5A5A_5A5A, 1'b1, '{1'b1, 17'd86400, 8'd1, 1'b0}},
		'{CMD_TICK, 32'hFFFF_FFFF, 1'b1, NIL},
		'{CMD_QUERY, 32'h5A5A_5A5A, 1'b1, '{1'b1, 17'd86400, 8'd1, 1'b0}},
		'{CMD_FAIL, 32'h5A5A_5A5A, 1'b0, NIL},
		'{CMD_FAIL, 32'hA5A5_A5A5, 1'b1, '{1'b1, 17'd86400, 8'd1, 1'b0}},
		'{CMD_CLEAR, 32'h1234_5678, 1'b1, NIL},
		'{CMD_QUERY, 32'hA5A5_A5A5, 1'b1, '{1'b1, 17'd86400, 8'd1, 1'b0}},
		'{CMD_CLEAR, 32'h5A5A_5A5A, 1'b1, NIL},
		'{CMD_CLEAR, 32'hA5A5_A5A5, 1'b1, NIL}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_MAX_ATTEMPTS;
	logic [CFG_W-1:0] cfg_data = '0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t command = CMD_TICK;
	logic [SRC_W-1:0] source_id = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic locked;
	logic [SEC_W-1:0] remaining_seconds;
	logic [COUNT_W-1:0] failure_count;
	logic status;

	failed_attempt_lockout_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.source_id(source_id),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.locked(locked),
		.remaining_seconds(remaining_seconds),
		.failure_count(failure_count),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the lockout table and its registers.
	logic slot_busy [TABLE_ENTRIES] = '{default: 1'b0};
	logic [SRC_W-1:0] slot_src [TABLE_ENTRIES];
	logic [COUNT_W-1:0] slot_hits [TABLE_ENTRIES];
	logic slot_barred [TABLE_ENTRIES];
	logic [TIME_W-1:0] slot_expiry [TABLE_ENTRIES];
	logic [TIME_W-1:0] clock_ms = '0;
	logic [COUNT_W-1:0] cfg_max_attempts = MAX_ATTEMPTS_RESET;
	logic [CFG_W-1:0] cfg_lockout_s = CFG_W'(300);

	verdict_t pending [$];
	logic [SRC_W-1:0] id_pool [$];
	int errors = 0;
	int words_sent = 0;
	int words_checked = 0;
	int locked_seen = 0;
	int dropped_seen = 0;
	int send_run_left = 0;
	logic send_quiet = 1'b0;
	int unsigned cycle_count = 0;

	function automatic int live_slot(logic [SRC_W-1:0] src);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (slot_busy[i] && clock_ms < slot_expiry[i] && slot_src[i] == src)
				return i;
		return -1;
	endfunction

	function automatic verdict_t slot_report(int idx);
		verdict_t v;
		logic [TIME_W-1:0] left;
		v = '0;
		if (idx >= 0) begin
			v.count = slot_hits[idx];
			if (slot_barred[idx]) begin
				left = slot_expiry[idx] - clock_ms;
				v.locked = 1'b1;
				v.seconds = SEC_W'((64'(left) + ROUND_UP) / MS_PER_SECOND);
			end
		end
		return v;
	endfunction

	function automatic verdict_t apply_command(cmd_t op, logic [SRC_W-1:0] src);
		verdict_t v;
		int idx;
		logic [63:0] deadline;
		v = '0;
		case (op)
			CMD_FAIL: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (slot_busy[i] && clock_ms >= slot_expiry[i])
						slot_busy[i] = 1'b0;
				idx = live_slot(src);
				if (idx < 0) begin
					for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
						if (!slot_busy[i])
							idx = i;
					if (idx >= 0) begin
						slot_busy[idx] = 1'b1;
						slot_src[idx] = src;
						slot_hits[idx] = '0;
						slot_barred[idx] = 1'b0;
					end
				end
				if (idx < 0) begin
					v.dropped = 1'b1;
				end else begin
					if (slot_hits[idx] != COUNT_MAX)
						slot_hits[idx]++;
					deadline = 64'(clock_ms) + 64'(cfg_lockout_s) * MS_PER_SECOND;
					slot_expiry[idx] = (deadline > 64'(TIME_MAX)) ? TIME_MAX : deadline[TIME_W-1:0];
					if (slot_hits[idx] >= cfg_max_attempts)
						slot_barred[idx] = 1'b1;
					v = slot_report(idx);
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (slot_busy[i] && slot_src[i] == src)
						slot_busy[i] = 1'b0;
			end
			CMD_QUERY: begin
				v = slot_report(live_slot(src));
			end
			CMD_TICK: begin
				if (clock_ms != TIME_MAX)
					clock_ms++;
			end
			default: ;
		endcase
		return v;
	endfunction

	function automatic void compare_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			errors++;
		end
	endfunction

	task automatic send_word(input cmd_t op, input logic [SRC_W-1:0] src, input logic known,
			input verdict_t want);
		int gap;
		verdict_t predicted;
		if (send_run_left == 0) begin
			send_quiet = ($urandom_range(0, 3) == 0);
			send_run_left = $urandom_range(20, 80);
		end
		send_run_left--;
		gap = send_quiet ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			command <= cmd_t'($urandom_range(0, 3));
			source_id <= $urandom;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= op;
		source_id <= src;
		do @(posedge clk); while (cmd_stall);
		predicted = apply_command(op, src);
		pending.push_back(known ? want : predicted);
		words_sent++;
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [COUNT_W-1:0] attempts, input logic [CFG_W-1:0] seconds);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAX_ATTEMPTS;
		cfg_data <= CFG_W'(attempts);
		@(posedge clk);
		cfg_index <= REG_LOCKOUT_SECONDS;
		cfg_data <= seconds;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_max_attempts = attempts;
		cfg_lockout_s = seconds;
	endtask

	task automatic fill_pool(input int size);
		id_pool.delete();
		repeat (size) id_pool.push_back($urandom);
	endtask

	task automatic clear_pool();
		foreach (id_pool[i])
			send_word(CMD_CLEAR, id_pool[i], 1'b0, NIL);
	endtask

	// When chasing expiry, sources whose deadline is one tick away or due now are, half the
	// time, queried or failed again, so the stale boundary is hit exactly.
	task automatic run_mix(input int words, input int pct_tick, input int pct_fail,
			input int pct_clear, input int pct_noise, input bit chase_expiry);
		cmd_t op;
		logic [SRC_W-1:0] src;
		int near;
		int pick;
		for (int n = 0; n < words; n++) begin
			near = -1;
			if (chase_expiry)
				for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
					if (slot_busy[i] && slot_expiry[i] >= clock_ms && slot_expiry[i] - clock_ms <= 1)
						near = i;
			if (near >= 0 && $urandom_range(0, 1) == 0) begin
				op = ($urandom_range(0, 2) == 0) ? CMD_FAIL : CMD_QUERY;
				src = slot_src[near];
			end else begin
				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 99) < pct_tick)
					op = CMD_TICK;
				else if (pick < pct_fail)
					op = CMD_FAIL;
				else if (pick < pct_fail + pct_clear)
					op = CMD_CLEAR;
				else
					op = CMD_QUERY;
				if ($urandom_range(0, 99) < pct_noise)
					src = $urandom;
				else
					src = id_pool[$urandom_range(0, id_pool.size() - 1)];
			end
			send_word(op, src, 1'b0, NIL);
		end
	endtask

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$error("run did not finish within %0d cycles", CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : result_side
		int hold;
		int run_left;
		logic quiet;
		verdict_t want;
		run_left = 0;
		quiet = 1'b0;
		forever begin
			if (run_left == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
				run_left = $urandom_range(20, 80);
			end
			run_left--;
			if (words_checked % 700 == 40)
				hold = HOLD_CYCLES;
			else
				hold = quiet ? 0 : $urandom_range(0, 18);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (rsp_valid !== 1'b1);
			if (pending.size() == 0) begin
				$error("result word arrived with no command waiting for it");
				errors++;
			end else begin
				want = pending.pop_front();
				compare_field("locked", 32'(want.locked), 32'(locked));
				compare_field("remaining_seconds", 32'(want.seconds), 32'(remaining_seconds));
				compare_field("failure_count", 32'(want.count), 32'(failure_count));
				compare_field("status", 32'(want.dropped), 32'(status));
				words_checked++;
				if (locked === 1'b1)
					locked_seen++;
				if (status === 1'b1)
					dropped_seen++;
			end
		end
	end

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < SCRIPT_LEN; i++) begin
			if (i == RECONFIG_ROW) begin
				drain();
				set_config(COUNT_W'(1), CFG_W'(86400));
			end
			send_word(SCRIPT[i].op, SCRIPT[i].src, SCRIPT[i].known, SCRIPT[i].want);
		end

		// Lockouts of one second, with enough ticks for early records to go stale.
		drain();
		set_config(COUNT_W'(2), CFG_W'(1));
		fill_pool(6);
		run_mix(60, 30, 60, 10, 8, 1'b0);
		run_mix(1100, 95, 40, 15, 8, 1'b1);
		clear_pool();

		// More sources than entries, so the table fills and failures are dropped.
		drain();
		set_config(COUNT_MAX, CFG_W'(86400));
		fill_pool(20);
		run_mix(120, 5, 75, 5, 0, 1'b0);
		clear_pool();

		// One source hammered past the saturation of its count.
		drain();
		set_config(COUNT_W'($urandom_range(1, 8)), CFG_W'($urandom_range(2, 600)));
		fill_pool(1);
		run_mix(340, 3, 95, 0, 8, 1'b0);
		clear_pool();

		drain();
		set_config(COUNT_W'($urandom_range(2, 4)), CFG_W'(1));
		fill_pool(8);
		run_mix(100, 40, 50, 15, 8, 1'b1);

		drain();
		repeat (40) @(posedge clk);
		$display("Checked %0d of %0d command words across six register settings.",
			words_checked, words_sent);
		$display("Results included %0d locked reports and %0d failures dropped on a full table.",
			locked_seen, dropped_seen);
		if (errors == 0 && pending.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
